FILE: hdl/nidlt_pkg.sv
// ----------------------------------------------------------------------------
// nidlt_pkg
// Shared types and codes for the network ID link table.
// ----------------------------------------------------------------------------
`default_nettype none

package nidlt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_REMOVE     = 2'd1,
    CMD_FIND_ID    = 2'd2,
    CMD_FIND_ENT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_ALREADY       = 3'd1,
    ST_NOT_LINKED    = 3'd2,
    ST_POOL_EMPTY    = 3'd3,
    ST_ID_OCCUPIED   = 3'd4,
    ST_ID_NOT_LINKED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ADDED   = 2'd1,
    EV_REMOVED = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  localparam int unsigned IN_BYTES  = 4;
  localparam int unsigned OUT_BYTES = 4;

endpackage

`default_nettype wire

FILE: hdl/nidlt_free_pool.sv
// ----------------------------------------------------------------------------
// nidlt_free_pool
// FIFO of free network IDs in a synchronous memory. Filled with 0..N-1 by
// the init sweep; pushes into a full pool are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module nidlt_free_pool #(
  parameter int NUM_IDS = 64,
  parameter int IW      = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          init_we,
  input  wire logic [IW-1:0] init_addr,
  input  wire logic          pop,
  input  wire logic          push,
  input  wire logic [IW-1:0] push_id,
  output logic      [IW-1:0] head_id,
  output logic               empty
);
  localparam int CW = $clog2(NUM_IDS + 1);
  localparam logic [IW-1:0] LAST = IW'(NUM_IDS - 1);

  logic [IW-1:0] fifo_mem [NUM_IDS];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] head_q_r;
  logic          full;
  logic          do_push;

  assign full    = (count_r == CW'(NUM_IDS));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign head_id = head_q_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    if (do_push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
    if (pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end else if (do_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= CW'(NUM_IDS);
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (init_we) begin
      fifo_mem[init_addr] <= init_addr;
    end else if (do_push) begin
      fifo_mem[tail_r] <= push_id;
    end
    head_q_r <= fifo_mem[head_r];
  end

endmodule

`default_nettype wire

FILE: hdl/network_id_link_table.sv
// ----------------------------------------------------------------------------
// network_id_link_table
// Two-way link between entity numbers and network IDs with a free ID pool.
// ----------------------------------------------------------------------------
// Flow: an entity lookup by ID reads and checks its ID (S_READ, S_CHECK); add,
//   remove and ID lookup scan the link memory one entry a cycle (S_SCAN).
// Commands: one at a time; a new one is taken while a result waits.
// Reset: synchronous; a sweep over all NUM_IDS entries then fills the free pool
//   and clears the link memory, with in_tready low throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module network_id_link_table #(
  parameter int NUM_IDS     = 64,
  parameter int ENTITY_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] cmd, [17:2] entity, [23:18] network_id, [24] use_given_id
  input  wire logic [nidlt_pkg::IN_BYTES*8-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] status, [8:3] result_id, [24:9] result_entity, [26:25] event_res
  output logic [nidlt_pkg::OUT_BYTES*8-1:0] out_tdata
);
  import nidlt_pkg::*;

  localparam int IW = (NUM_IDS > 2) ? $clog2(NUM_IDS) : 1;
  localparam int EW = ENTITY_BITS;
  localparam logic [IW-1:0] LAST = IW'(NUM_IDS - 1);

  // input fields
  logic [1:0]  in_cmd;
  logic [15:0] in_entity;
  logic [5:0]  in_nid;
  logic        in_given;
  logic [31:0] in_ent_wide;
  logic [EW-1:0] in_ent;
  logic [15:0] in_nid_wide;
  logic        in_nid_ok;

  assign in_cmd      = in_tdata[1:0];
  assign in_entity   = in_tdata[17:2];
  assign in_nid      = in_tdata[23:18];
  assign in_given    = in_tdata[24];
  assign in_ent_wide = 32'(in_entity);
  assign in_ent      = in_ent_wide[EW-1:0];
  assign in_nid_wide = 16'(in_nid);
  assign in_nid_ok   = (32'(in_nid) < 32'(NUM_IDS));

  state_t        state_r, state_nxt;
  logic [IW-1:0] init_cnt_r, init_cnt_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [5:0]    nid_r, nid_nxt;
  logic          given_r, given_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic          scan_end_r, scan_end_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  status_t       res_status_r, res_status_nxt;
  logic [IW-1:0] res_id_r, res_id_nxt;
  logic [EW-1:0] res_ent_r, res_ent_nxt;
  event_t        res_ev_r, res_ev_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [5:0]    out_id_r, out_id_nxt;
  logic [15:0]   out_ent_r, out_ent_nxt;
  event_t        out_ev_r, out_ev_nxt;

  // link memory: bit EW is the in-use flag
  logic [EW:0]   link_mem [NUM_IDS];
  logic [EW:0]   link_q_r;
  logic [IW-1:0] rd_addr;
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [EW:0]   lw_data;

  logic          pool_pop, pool_push, pool_empty, pool_init;
  logic [IW-1:0] pool_head;

  logic          hit, scan_last;
  logic [15:0]   nid_r_wide, res_id_wide;
  logic          nid_r_ok;
  logic [31:0]   res_ent_wide;

  assign hit        = cmp_vld_r && link_q_r[EW] && (link_q_r[EW-1:0] == ent_r);
  assign scan_last  = cmp_vld_r && (cmp_idx_r == LAST);
  assign nid_r_wide = 16'(nid_r);
  assign nid_r_ok   = (32'(nid_r) < 32'(NUM_IDS));
  assign res_id_wide  = 16'(res_id_r);
  assign res_ent_wide = 32'(res_ent_r);
  assign pool_init  = (state_r == S_INIT);

  nidlt_free_pool #(
    .NUM_IDS (NUM_IDS),
    .IW      (IW)
  ) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_we   (pool_init),
    .init_addr (init_cnt_r),
    .pop       (pool_pop),
    .push      (pool_push),
    .push_id   (cmp_idx_r),
    .head_id   (pool_head),
    .empty     (pool_empty)
  );

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    cmd_nxt        = cmd_r;
    ent_nxt        = ent_r;
    nid_nxt        = nid_r;
    given_nxt      = given_r;
    tgt_nxt        = tgt_r;
    scan_idx_nxt   = scan_idx_r;
    scan_end_nxt   = scan_end_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_ent_nxt    = res_ent_r;
    res_ev_nxt     = res_ev_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_ent_nxt    = out_ent_r;
    out_ev_nxt     = out_ev_r;
    rd_addr        = tgt_r;
    lw_en          = 1'b0;
    lw_addr        = tgt_r;
    lw_data        = {1'b1, ent_r};
    pool_pop       = 1'b0;
    pool_push      = 1'b0;
    in_tready      = 1'b0;

    unique case (state_r)
      S_INIT: begin
        lw_en        = 1'b1;
        lw_addr      = init_cnt_r;
        lw_data      = '0;
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt        = cmd_t'(in_cmd);
          ent_nxt        = in_ent;
          nid_nxt        = in_nid;
          given_nxt      = in_given;
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_ent_nxt    = in_ent;
          res_ev_nxt     = EV_NONE;
          scan_idx_nxt   = '0;
          scan_end_nxt   = 1'b0;
          if (cmd_t'(in_cmd) == CMD_FIND_ENT) begin
            if (in_nid_ok) begin
              tgt_nxt   = in_nid_wide[IW-1:0];
              state_nxt = S_READ;
            end else begin
              res_status_nxt = ST_ID_NOT_LINKED;
              state_nxt      = S_DONE;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        rd_addr     = scan_idx_r;
        cmp_vld_nxt = !scan_end_r;
        cmp_idx_nxt = scan_idx_r;
        if (scan_idx_r == LAST) begin
          scan_end_nxt = 1'b1;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (hit || scan_last) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_DONE;
          unique case (cmd_r)
            CMD_FIND_ID: begin
              if (hit) begin
                res_id_nxt = cmp_idx_r;
              end else begin
                res_status_nxt = ST_NOT_LINKED;
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                lw_en      = 1'b1;
                lw_addr    = cmp_idx_r;
                lw_data    = {1'b0, link_q_r[EW-1:0]};
                pool_push  = 1'b1;
                res_id_nxt = cmp_idx_r;
                res_ev_nxt = EV_REMOVED;
              end else begin
                res_status_nxt = ST_NOT_LINKED;
              end
            end
            CMD_ADD: begin
              priority if (hit) begin
                res_status_nxt = ST_ALREADY;
              end else if (given_r && nid_r_ok) begin
                tgt_nxt   = nid_r_wide[IW-1:0];
                state_nxt = S_READ;
              end else if (pool_empty) begin
                res_status_nxt = ST_POOL_EMPTY;
              end else begin
                tgt_nxt   = pool_head;
                pool_pop  = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        rd_addr   = tgt_r;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_FIND_ENT) begin
          if (link_q_r[EW]) begin
            res_id_nxt  = tgt_r;
            res_ent_nxt = link_q_r[EW-1:0];
          end else begin
            res_status_nxt = ST_ID_NOT_LINKED;
          end
        end else begin
          if (link_q_r[EW]) begin
            res_status_nxt = ST_ID_OCCUPIED;
          end else begin
            lw_en      = 1'b1;
            lw_addr    = tgt_r;
            lw_data    = {1'b1, ent_r};
            res_id_nxt = tgt_r;
            res_ev_nxt = EV_ADDED;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_wide[5:0];
          out_ent_nxt    = res_ent_wide[15:0];
          out_ev_nxt     = res_ev_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      scan_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      scan_end_r  <= scan_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ent_r        <= ent_nxt;
    nid_r        <= nid_nxt;
    given_r      <= given_nxt;
    tgt_r        <= tgt_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_ent_r    <= res_ent_nxt;
    res_ev_r     <= res_ev_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_ent_r    <= out_ent_nxt;
    out_ev_r     <= out_ev_nxt;
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    link_q_r <= link_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_ev_r, out_ent_r, out_id_r, out_status_r};

endmodule

`default_nettype wire

FILE: tb/network_id_link_table_chk.sv
// ----------------------------------------------------------------------------
// network_id_link_table_chk
// Watches both streams of the link table. Each command transfer is run through
// a local copy of the link memory and free pool, and each result transfer is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module network_id_link_table_chk
  import nidlt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [IN_BYTES*8-1:0]    in_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_BYTES*8-1:0]   out_tdata,
  output int                       mismatches,
  output int                       pending,
  output int                       results,
  output int                       pool_empty_hits,
  output int                       stale_hits,
  output int                       full_pool_drops
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINK_SLOTS = 64;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    status_t     status;
    logic [5:0]  id;
    logic [15:0] ent;
    event_t      ev;
  } link_result_t;

  logic [15:0]  link_ent  [LINK_SLOTS];
  bit           link_used [LINK_SLOTS];
  logic [5:0]   free_ids  [LINK_SLOTS];
  logic [5:0]   free_rd;
  logic [5:0]   free_wr;
  int           free_cnt;
  link_result_t expected_results [$];

  function automatic void clear_links();
    for (int i = 0; i < LINK_SLOTS; i++) begin
      link_ent[i]  = '0;
      link_used[i] = 1'b0;
      free_ids[i]  = 6'(i);
    end
    free_rd  = '0;
    free_wr  = '0;
    free_cnt = LINK_SLOTS;
  endfunction

  function automatic bit lookup_entity(input logic [15:0] ent, output logic [5:0] id);
    id = '0;
    for (int i = 0; i < LINK_SLOTS; i++) begin
      if (link_used[i] && link_ent[i] == ent) begin
        id = 6'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic link_result_t apply_link_cmd(input cmd_t c, input logic [15:0] ent,
                                                  input logic [5:0] nid, input logic given);
    link_result_t r;
    logic [5:0]   id;
    r = '{status: ST_OK, id: '0, ent: ent, ev: EV_NONE};
    case (c)
      CMD_ADD: begin
        if (lookup_entity(ent, id)) begin
          r.status = ST_ALREADY;
        end else if (given) begin
          if (link_used[nid]) begin
            r.status = ST_ID_OCCUPIED;
          end else begin
            link_ent[nid]  = ent;
            link_used[nid] = 1'b1;
            r.id = nid;
            r.ev = EV_ADDED;
          end
        end else if (free_cnt == 0) begin
          r.status = ST_POOL_EMPTY;
          pool_empty_hits++;
        end else begin
          id = free_ids[free_rd];
          free_rd++;
          free_cnt--;
          if (link_used[id]) begin
            // pool entry went stale through a given-ID add: dropped
            r.status = ST_ID_OCCUPIED;
            stale_hits++;
          end else begin
            link_ent[id]  = ent;
            link_used[id] = 1'b1;
            r.id = id;
            r.ev = EV_ADDED;
          end
        end
      end
      CMD_REMOVE: begin
        if (!lookup_entity(ent, id)) begin
          r.status = ST_NOT_LINKED;
        end else begin
          link_used[id] = 1'b0;
          if (free_cnt < LINK_SLOTS) begin
            free_ids[free_wr] = id;
            free_wr++;
            free_cnt++;
          end else begin
            full_pool_drops++;
          end
          r.id = id;
          r.ev = EV_REMOVED;
        end
      end
      CMD_FIND_ID: begin
        if (lookup_entity(ent, id)) r.id = id;
        else r.status = ST_NOT_LINKED;
      end
      default: begin
        if (link_used[nid]) begin
          r.id  = nid;
          r.ent = link_ent[nid];
        end else begin
          r.status = ST_ID_NOT_LINKED;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    link_result_t want;
    if (!rst_n) begin
      clear_links();
      expected_results.delete();
      mismatches      = 0;
      results         = 0;
      pool_empty_hits = 0;
      stale_hits      = 0;
      full_pool_drops = 0;
      pending <= 0;
    end else begin
      // result first: it always belongs to an earlier command
      if (out_tvalid && out_tready) begin
        results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got %0h", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(out_tdata[2:0]), 16'(want.status));
          check_field("result_id", 16'(out_tdata[8:3]), 16'(want.id));
          check_field("result_entity", out_tdata[24:9], want.ent);
          check_field("event_res", 16'(out_tdata[26:25]), 16'(want.ev));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_link_cmd(cmd_t'(in_tdata[1:0]), in_tdata[17:2],
                                                  in_tdata[23:18], in_tdata[24]));
      pending <= expected_results.size();
    end
  end

endmodule

FILE: tb/network_id_link_table_tb.sv
// ----------------------------------------------------------------------------
// network_id_link_table_tb
// Drives add, remove and both lookups into the link table: a directed opening
// over the corner cases, then random fill, drain and mixed phases over a small
// entity set with some full-range noise. Bursty sender, stalling receiver;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module network_id_link_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nidlt_pkg::*;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int ENT_SET_SIZE   = 96;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [1:0] cmd, [17:2] entity, [23:18] network_id, [24] use_given_id
  logic [IN_BYTES*8-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [2:0] status, [8:3] result_id, [24:9] result_entity, [26:25] event_res
  logic [OUT_BYTES*8-1:0] out_tdata;

  int mismatches, pending, results, pool_empty_hits, stale_hits, full_pool_drops;
  int cmd_count [4];
  int sent_total  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int rdy_left    = 0;
  int rdy_mode    = 0;
  logic [15:0] ent_set [ENT_SET_SIZE];

  network_id_link_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  network_id_link_table_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results         (results),
    .pool_empty_hits (pool_empty_hits),
    .stale_hits      (stale_hits),
    .full_pool_drops (full_pool_drops)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: free-running, fully stalled and random stretches
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      case (rdy_mode)
        0:       rdy_left = $urandom_range(20, 300);
        1:       rdy_left = $urandom_range(1, 120);
        default: rdy_left = $urandom_range(10, 200);
      endcase
    end
    rdy_left--;
    case (rdy_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'b0;
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input cmd_t c, input logic [15:0] ent, input logic [5:0] nid,
                          input logic given);
    int gap;
    in_tdata  <= {7'd0, given, nid, ent, c};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    cmd_count[c]++;
    sent_total++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int len, input phase_t ph);
    int          r;
    int          add_pct;
    int          rem_pct;
    cmd_t        c;
    logic [15:0] ent;
    case (ph)
      PH_FILL:  begin add_pct = 75; rem_pct = 10; end
      PH_DRAIN: begin add_pct = 20; rem_pct = 60; end
      default:  begin add_pct = 35; rem_pct = 30; end
    endcase
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) c = CMD_ADD;
      else if (r < add_pct + rem_pct) c = CMD_REMOVE;
      else if (r % 2 == 0) c = CMD_FIND_ID;
      else c = CMD_FIND_ENT;
      if ($urandom_range(0, 19) == 0) c = cmd_t'($urandom_range(0, 3));
      ent = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                        : ent_set[$urandom_range(0, ENT_SET_SIZE - 1)];
      send_cmd(c, ent, 6'($urandom_range(0, 63)), ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    for (int i = 0; i < ENT_SET_SIZE; i++) ent_set[i] = 16'($urandom);
    ent_set[0] = 16'h0000;
    ent_set[1] = 16'hFFFF;
    burst_left = $urandom_range(1, 12);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // lookups and remove on an empty table
    send_cmd(CMD_FIND_ID,  16'h0000, 6'd0,  1'b0);
    send_cmd(CMD_FIND_ENT, 16'h0000, 6'd63, 1'b0);
    send_cmd(CMD_REMOVE,   16'hFFFF, 6'd0,  1'b0);
    // remove while the pool is still full: pushed ID is dropped
    send_cmd(CMD_ADD,      16'h8001, 6'd40, 1'b1);
    send_cmd(CMD_REMOVE,   16'h8001, 6'd0,  1'b0);
    send_cmd(CMD_ADD,      16'h0000, 6'd63, 1'b0);
    send_cmd(CMD_ADD,      16'hFFFF, 6'd0,  1'b0);
    send_cmd(CMD_ADD,      16'h0000, 6'd5,  1'b0);
    send_cmd(CMD_ADD,      16'hA5A5, 6'd63, 1'b1);
    send_cmd(CMD_ADD,      16'h5A5A, 6'd63, 1'b1);
    send_cmd(CMD_ADD,      16'h5A5A, 6'd0,  1'b1);
    // given ID 2 leaves a stale entry at the pool head
    send_cmd(CMD_ADD,      16'h5A5A, 6'd2,  1'b1);
    send_cmd(CMD_ADD,      16'h1234, 6'd0,  1'b0);
    send_cmd(CMD_ADD,      16'h1234, 6'd0,  1'b0);
    send_cmd(CMD_FIND_ID,  16'hFFFF, 6'd0,  1'b0);
    send_cmd(CMD_FIND_ENT, 16'h0000, 6'd63, 1'b0);
    send_cmd(CMD_FIND_ENT, 16'h0000, 6'd0,  1'b0);
    send_cmd(CMD_REMOVE,   16'hFFFF, 6'd0,  1'b0);
    send_cmd(CMD_REMOVE,   16'h0000, 6'd0,  1'b0);
    send_cmd(CMD_FIND_ID,  16'h0000, 6'd0,  1'b0);
    send_cmd(CMD_REMOVE,   16'h1234, 6'd0,  1'b0);
    send_cmd(CMD_REMOVE,   16'hA5A5, 6'd0,  1'b0);
    send_cmd(CMD_REMOVE,   16'h5A5A, 6'd0,  1'b0);
    hold_until_drained();

    while (sent_total < RANDOM_ITEMS) begin
      run_random_phase($urandom_range(40, 200), phase_t'($urandom_range(0, 2)));
      if ($urandom_range(0, 4) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (add %0d, remove %0d, find-id %0d, find-entity %0d), %0d results",
             sent_total, cmd_count[CMD_ADD], cmd_count[CMD_REMOVE], cmd_count[CMD_FIND_ID],
             cmd_count[CMD_FIND_ENT], results);
    $display("Pool-empty rejects %0d, stale pool entries %0d, drops on full pool %0d",
             pool_empty_hits, stale_hits, full_pool_drops);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/nidlt_pkg.sv
hdl/nidlt_free_pool.sv
hdl/network_id_link_table.sv
tb/network_id_link_table_chk.sv
tb/network_id_link_table_tb.sv
